>>> rtl/spr_pkg.sv
// Shared types and constants for the spin precession rotator.
// Holds the CORDIC arctangent table, fixed widths and register/axis codes.
// No dependencies.
`timescale 1ns / 1ps

package spr_pkg;

    // Fixed field widths
    localparam int PHASE_W     = 32;
    localparam int POS_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int AXIS_W      = 2;

    // CORDIC arrangement
    localparam int GUARD_BITS      = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int STEPS_PER_STAGE = 3;
    localparam int ATAN_W          = 30;
    localparam int GAIN_W          = 31;
    localparam int GAIN_SHIFT      = 30 - GUARD_BITS;

    // Residual angle width: wide enough for the reduced angle plus the table sum
    localparam int PHI_W = 34;

    // Inverse CORDIC gain in Q30
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

    // Binary angle turn fractions, in the residual angle width
    localparam logic signed [PHI_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [PHI_W-1:0] HALF_TURN    = 34'sd2147483648;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd1;

    // Rotation axis codes
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    // Arctangent of 2^-i in binary angle units (2^32 per turn)
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/spin_precession_rotate.sv
// Spin precession rotator: rotates one magnetization vector per transaction
// about the configured axis by phase_per_position * position. Depends on spr_pkg.
// Pipeline: angle multiply, gain multiply and quadrant fold, eight CORDIC stages
// of three micro-rotations each, then rounding into the result register.
// Throughput: one transaction per cycle; a held result stalls the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and both config registers.
`timescale 1ns / 1ps

module spin_precession_rotate #(
    parameter int MAG_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [MAG_WIDTH-1:0]   i_mag_x,
    input  logic signed [MAG_WIDTH-1:0]   i_mag_y,
    input  logic signed [MAG_WIDTH-1:0]   i_mag_z,
    input  logic signed [spr_pkg::POS_W-1:0] i_position,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [MAG_WIDTH-1:0]   o_rot_x,
    output logic signed [MAG_WIDTH-1:0]   o_rot_y,
    output logic signed [MAG_WIDTH-1:0]   o_rot_z
);

    import spr_pkg::*;

    localparam int NSTG = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int NTOT = NSTG + 3;
    localparam int CW   = MAG_WIDTH + GUARD_BITS + 3;
    localparam int PW   = MAG_WIDTH + GAIN_W + 1;
    localparam int RW   = CW - GUARD_BITS;

    localparam logic signed [CW-1:0] ROUND_HALF = CW'(1) <<< (GUARD_BITS - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (MAG_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    // Configuration registers
    logic signed [PHASE_W-1:0] r_ppp;
    logic [AXIS_W-1:0]         r_axis;

    // Pipeline control
    logic [NTOT-1:0] r_vld;
    logic            en;

    // Side data carried alongside the rotation, positions 0 .. NTOT-2
    logic signed [MAG_WIDTH-1:0] r_mx   [NTOT-1];
    logic signed [MAG_WIDTH-1:0] r_my   [NTOT-1];
    logic signed [MAG_WIDTH-1:0] r_mz   [NTOT-1];
    logic [AXIS_W-1:0]           r_axp  [NTOT-1];

    // Stage 1: angle and selected pair
    logic signed [PHASE_W-1:0]   r_theta, n_theta;
    logic signed [MAG_WIDTH-1:0] r_a, r_b, n_a, n_b;

    // Stage 2 onwards: CORDIC state (index 0 is the stage-2 register)
    logic signed [CW-1:0]    r_cx [NSTG+1];
    logic signed [CW-1:0]    r_cy [NSTG+1];
    logic signed [PHI_W-1:0] r_cz [NSTG+1];

    // Stage 2 combinational
    logic signed [PHI_W-1:0]     n_phi, phi_raw;
    logic                        n_flip;
    logic signed [MAG_WIDTH:0]   a_ext, b_ext;
    logic signed [PW-1:0]        prod_a, prod_b;

    // Output stage
    logic signed [CW-1:0]        rnd_x, rnd_y;
    logic signed [RW-1:0]        sh_x, sh_y;
    logic signed [MAG_WIDTH-1:0] sat_x, sat_y;
    logic signed [MAG_WIDTH-1:0] n_rot_x, n_rot_y, n_rot_z;
    logic signed [MAG_WIDTH-1:0] r_rot_x, r_rot_y, r_rot_z;

    // Advance the whole pipeline unless a finished result is held
    assign en          = !(r_vld[NTOT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppp  <= '0;
            r_axis <= AXIS_Z;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PHASE: r_ppp  <= $signed(i_cfg_data[PHASE_W-1:0]);
                REG_AXIS:  r_axis <= i_cfg_data[AXIS_W-1:0];
                default:   ;
            endcase
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NTOT-2:0], i_in_valid};
        end
    end

    // Shift the untouched components and the axis code along
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx[0]  <= i_mag_x;
            r_my[0]  <= i_mag_y;
            r_mz[0]  <= i_mag_z;
            r_axp[0] <= r_axis;
            for (int k = 1; k < NTOT - 1; k++) begin
                r_mx[k]  <= r_mx[k-1];
                r_my[k]  <= r_my[k-1];
                r_mz[k]  <= r_mz[k-1];
                r_axp[k] <= r_axp[k-1];
            end
        end
    end

    // Stage 1: angle product modulo one turn, pick the rotated pair
    assign n_theta = r_ppp * PHASE_W'(i_position);

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                n_a = i_mag_y;
                n_b = i_mag_z;
            end
            AXIS_Y: begin
                n_a = i_mag_x;
                n_b = i_mag_z;
            end
            default: begin
                n_a = i_mag_x;
                n_b = i_mag_y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta <= n_theta;
            r_a     <= n_a;
            r_b     <= n_b;
        end
    end

    // Stage 2: negate the angle, fold into half a turn, apply the CORDIC gain
    always_comb begin
        phi_raw = PHI_W'(-r_theta);
        n_phi   = phi_raw;
        n_flip  = 1'b0;
        if (phi_raw > QUARTER_TURN) begin
            n_phi  = phi_raw - HALF_TURN;
            n_flip = 1'b1;
        end else if (phi_raw < -QUARTER_TURN) begin
            n_phi  = phi_raw + HALF_TURN;
            n_flip = 1'b1;
        end
        a_ext  = n_flip ? -(MAG_WIDTH+1)'(r_a) : (MAG_WIDTH+1)'(r_a);
        b_ext  = n_flip ? -(MAG_WIDTH+1)'(r_b) : (MAG_WIDTH+1)'(r_b);
        prod_a = PW'(a_ext) * PW'(GAIN_Q30);
        prod_b = PW'(b_ext) * PW'(GAIN_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= CW'(prod_a >>> GAIN_SHIFT);
            r_cy[0] <= CW'(prod_b >>> GAIN_SHIFT);
            r_cz[0] <= n_phi;
        end
    end

    // CORDIC stages: three micro-rotations each, residual sign picks direction
    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        logic signed [CW-1:0]    n_x, n_y, t_dx, t_dy;
        logic signed [PHI_W-1:0] n_z, t_at;

        always_comb begin
            n_x  = r_cx[g];
            n_y  = r_cy[g];
            n_z  = r_cz[g];
            t_dx = '0;
            t_dy = '0;
            t_at = '0;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                t_dx = n_y >>> (g * STEPS_PER_STAGE + j);
                t_dy = n_x >>> (g * STEPS_PER_STAGE + j);
                t_at = $signed({{(PHI_W-ATAN_W){1'b0}},
                                atan_lut(5'(g * STEPS_PER_STAGE + j))});
                if (!n_z[PHI_W-1]) begin
                    n_x = n_x - t_dx;
                    n_y = n_y + t_dy;
                    n_z = n_z - t_at;
                end else begin
                    n_x = n_x + t_dx;
                    n_y = n_y - t_dy;
                    n_z = n_z + t_at;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[g+1] <= n_x;
                r_cy[g+1] <= n_y;
                r_cz[g+1] <= n_z;
            end
        end
    end

    // Output stage: round off the guard bits, saturate, put the pair back
    always_comb begin
        rnd_x = r_cx[NSTG] + ROUND_HALF;
        rnd_y = r_cy[NSTG] + ROUND_HALF;
        sh_x  = RW'(rnd_x >>> GUARD_BITS);
        sh_y  = RW'(rnd_y >>> GUARD_BITS);
        if (sh_x > SAT_HI)      sat_x = MAG_WIDTH'(SAT_HI);
        else if (sh_x < SAT_LO) sat_x = MAG_WIDTH'(SAT_LO);
        else                    sat_x = MAG_WIDTH'(sh_x);
        if (sh_y > SAT_HI)      sat_y = MAG_WIDTH'(SAT_HI);
        else if (sh_y < SAT_LO) sat_y = MAG_WIDTH'(SAT_LO);
        else                    sat_y = MAG_WIDTH'(sh_y);

        case (r_axp[NTOT-2])
            AXIS_Z: begin
                n_rot_x = sat_x;
                n_rot_y = sat_y;
                n_rot_z = r_mz[NTOT-2];
            end
            AXIS_X: begin
                n_rot_x = r_mx[NTOT-2];
                n_rot_y = sat_x;
                n_rot_z = sat_y;
            end
            AXIS_Y: begin
                n_rot_x = sat_x;
                n_rot_y = r_my[NTOT-2];
                n_rot_z = sat_y;
            end
            default: begin
                n_rot_x = r_mx[NTOT-2];
                n_rot_y = r_my[NTOT-2];
                n_rot_z = r_mz[NTOT-2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot_x <= n_rot_x;
            r_rot_y <= n_rot_y;
            r_rot_z <= n_rot_z;
        end
    end

    assign o_out_valid = r_vld[NTOT-1];
    assign o_rot_x     = r_rot_x;
    assign o_rot_y     = r_rot_y;
    assign o_rot_z     = r_rot_z;

    // Folded angle stays within a quarter turn either side
    a_phi_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_cz[0] <= QUARTER_TURN && r_cz[0] >= -QUARTER_TURN))
        else $error("folded angle outside a quarter turn");

    // CORDIC residual must have converged by the last stage
    a_residual_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG+1] |-> (r_cz[NSTG] < 34'sd1024 && r_cz[NSTG] > -34'sd1024))
        else $error("CORDIC residual angle did not converge");

    // A held pipeline must not move its valid bits
    a_hold_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved while the pipeline was held");

endmodule

>>> verif/tb_spin_precession_rotate.sv
// Self-checking testbench for spin_precession_rotate: directed and random spins
// under several register settings, checked against an in-bench CORDIC predictor.
// Depends on spr_pkg and the spin_precession_rotate RTL.
`timescale 1ns / 1ps

module tb_spin_precession_rotate;

    import spr_pkg::*;

    localparam int MAG_W         = 16;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int LATENCY_SLACK = 24;
    localparam int TIMEOUT_NS    = 3_000_000;

    // Unused register slots, written only to show they are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Predictor arithmetic
    localparam int     FRAC_GUARD  = 16;
    localparam int     MICRO_ROTS  = 24;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint QUARTER_BAM = 64'sd1073741824;
    localparam longint HALF_BAM    = 64'sd2147483648;
    localparam longint MAG_MAX     = (64'sd1 <<< (MAG_W - 1)) - 1;
    localparam longint MAG_MIN     = -MAG_MAX - 1;

    typedef struct packed {
        logic signed [MAG_W-1:0] x;
        logic signed [MAG_W-1:0] y;
        logic signed [MAG_W-1:0] z;
    } t_spin_vec;

    // Arctangent of 2^-i in binary angle units
    longint arctan_units [0:MICRO_ROTS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = '0;
    logic [CFG_DATA_W-1:0]   cfg_data   = '0;
    logic                    in_valid   = 1'b0;
    logic signed [MAG_W-1:0] mag_x      = '0;
    logic signed [MAG_W-1:0] mag_y      = '0;
    logic signed [MAG_W-1:0] mag_z      = '0;
    logic signed [POS_W-1:0] position   = '0;
    logic                    out_stall  = 1'b0;
    logic                    o_cfg_ready;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [MAG_W-1:0] o_rot_x;
    logic signed [MAG_W-1:0] o_rot_y;
    logic signed [MAG_W-1:0] o_rot_z;

    // Shadow registers, as the block should hold them
    logic [PHASE_W-1:0] phase_reg = '0;
    logic [AXIS_W-1:0]  axis_reg  = AXIS_Z;

    t_spin_vec expected_rotations [$];
    t_spin_vec oldest_rotation;
    int        errors          = 0;
    int        spins_sent      = 0;
    int        rotations_seen  = 0;
    int        settings_used   = 0;

    int        stall_mode      = 0;
    int        stall_left      = 0;

    spin_precession_rotate #(
        .MAG_WIDTH (MAG_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_mag_x     (mag_x),
        .i_mag_y     (mag_y),
        .i_mag_z     (mag_z),
        .i_position  (position),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    initial begin
        #TIMEOUT_NS;
        $display("%0t: timeout with %0d rotations outstanding", $time,
                 expected_rotations.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Round away the guard bits and clamp to the magnetisation range
    function automatic logic signed [MAG_W-1:0] round_clamp(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (FRAC_GUARD - 1))) >>> FRAC_GUARD;
        if (r > MAG_MAX) r = MAG_MAX;
        if (r < MAG_MIN) r = MAG_MIN;
        return r[MAG_W-1:0];
    endfunction

    // Rotate the pair (a, b) by minus the binary angle theta through the CORDIC steps
    function automatic logic [2*MAG_W-1:0] precess_pair(input logic signed [MAG_W-1:0] a,
                                                        input logic signed [MAG_W-1:0] b,
                                                        input logic [PHASE_W-1:0] theta);
        logic [PHASE_W-1:0] neg_theta;
        longint             phi;
        longint             xa;
        longint             yb;
        longint             dx;
        longint             dy;
        neg_theta = -theta;
        phi = longint'($signed(neg_theta));
        xa  = longint'(a);
        yb  = longint'(b);
        // Fold the angle into the right half plane by a half turn
        if (phi > QUARTER_BAM) begin
            phi = phi - HALF_BAM;
            xa  = -xa;
            yb  = -yb;
        end else if (phi < -QUARTER_BAM) begin
            phi = phi + HALF_BAM;
            xa  = -xa;
            yb  = -yb;
        end
        xa = (xa * ROT_GAIN) >>> (30 - FRAC_GUARD);
        yb = (yb * ROT_GAIN) >>> (30 - FRAC_GUARD);
        for (int k = 0; k < MICRO_ROTS; k++) begin
            dx = yb >>> k;
            dy = xa >>> k;
            if (phi >= 0) begin
                xa  = xa - dx;
                yb  = yb + dy;
                phi = phi - arctan_units[k];
            end else begin
                xa  = xa + dx;
                yb  = yb - dy;
                phi = phi + arctan_units[k];
            end
        end
        return {round_clamp(xa), round_clamp(yb)};
    endfunction

    // Expected rotated vector for one spin under the current shadow registers
    function automatic t_spin_vec precess_spin(input t_spin_vec mag,
                                               input logic [POS_W-1:0] pos);
        logic [PHASE_W-1:0] pos_ext;
        logic [PHASE_W-1:0] theta;
        t_spin_vec          rot;
        pos_ext = {{(PHASE_W - POS_W){pos[POS_W-1]}}, pos};
        theta   = phase_reg * pos_ext;
        rot     = mag;
        case (axis_reg)
            AXIS_Z:  {rot.x, rot.y} = precess_pair(mag.x, mag.y, theta);
            AXIS_X:  {rot.y, rot.z} = precess_pair(mag.y, mag.z, theta);
            AXIS_Y:  {rot.x, rot.z} = precess_pair(mag.x, mag.z, theta);
            default: rot = mag;
        endcase
        return rot;
    endfunction

    function automatic logic [MAG_W-1:0] pick_mag();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(MAG_W - 1){1'b1}}};
            1:       return {1'b1, {(MAG_W - 1){1'b0}}};
            2:       return '0;
            default: return MAG_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return POS_W'($urandom_range(0, 31)) - POS_W'(16);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic t_spin_vec random_spin();
        t_spin_vec m;
        m.x = pick_mag();
        m.y = pick_mag();
        m.z = pick_mag();
        return m;
    endfunction

    task automatic report_field(input string name, input logic signed [MAG_W-1:0] want,
                                input logic signed [MAG_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     want, got);
        end
    endtask

    // Receiver stall pattern: switch at random between four styles
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= (stall_left % 5 < 2);
        endcase
    end

    // Compare each result transaction with the oldest expected rotation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_rotations.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual (%0d, %0d, %0d)",
                         $time, o_rot_x, o_rot_y, o_rot_z);
            end else begin
                oldest_rotation = expected_rotations.pop_front();
                rotations_seen++;
                report_field("rot_x", oldest_rotation.x, o_rot_x);
                report_field("rot_y", oldest_rotation.y, o_rot_y);
                report_field("rot_z", oldest_rotation.z, o_rot_z);
            end
        end
    end

    // Offer one spin and hold it until the block takes it
    task automatic send_spin(input t_spin_vec mag, input logic [POS_W-1:0] pos);
        in_valid <= 1'b1;
        mag_x    <= mag.x;
        mag_y    <= mag.y;
        mag_z    <= mag.z;
        position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_rotations.push_back(precess_spin(mag, pos));
        spins_sent++;
    endtask

    task automatic send_fields(input logic [MAG_W-1:0] x, input logic [MAG_W-1:0] y,
                               input logic [MAG_W-1:0] z, input logic [POS_W-1:0] pos);
        t_spin_vec m;
        m.x = x;
        m.y = y;
        m.z = z;
        send_spin(m, pos);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_rotations.size() != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_PHASE)
            phase_reg = data;
        else if (idx == REG_AXIS)
            axis_reg = data[AXIS_W-1:0];
    endtask

    task automatic program_regs(input logic [31:0] phase, input logic [31:0] axis_word,
                                input bit poke_spare);
        wait_idle();
        write_reg(REG_PHASE, phase);
        write_reg(REG_AXIS, axis_word);
        if (poke_spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        cfg_valid <= 1'b0;
        settings_used++;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic stream_random(input int count, input bit gaps_on);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) send_spin(random_spin(), pick_pos());
            left -= burst;
            if (gaps_on) hold_off($urandom_range(0, 6));
        end
    endtask

    // Registers at their reset values: no rotation angle, z axis
    task automatic test_reset_state();
        send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_fields(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Eighth-turn steps about every axis code, including the pass-through one;
    // full-scale vectors at 45 degrees drive the outputs into saturation
    task automatic test_each_axis();
        logic [AXIS_W-1:0] axis_code;
        for (int a = 0; a < 4; a++) begin
            case (a)
                0:       axis_code = AXIS_Z;
                1:       axis_code = AXIS_X;
                2:       axis_code = AXIS_Y;
                default: axis_code = AXIS_NONE;
            endcase
            program_regs(32'h2000_0000, {30'd0, axis_code}, 1'b0);
            send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1);
            send_fields(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
            hold_off(1);
            send_fields(16'h7FFF, 16'h8000, 16'd12345, 16'd2);
            send_fields(16'h8000, 16'h7FFF, 16'hFFFF, 16'd4);
        end
    endtask

    // Extreme phase steps times extreme positions wrap round the turn
    task automatic test_angle_wrap();
        program_regs(32'h7FFF_FFFF, {30'd0, AXIS_Z}, 1'b1);
        send_fields(16'h4000, 16'hC000, 16'h1234, 16'h7FFF);
        send_fields(16'h7FFF, 16'h0001, 16'h8000, 16'h8000);
        program_regs(32'h8000_0000, {30'h3FFF_FFFF, AXIS_X}, 1'b1);
        send_fields(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    endtask

    // Random spins in bursts under a sequence of register settings
    task automatic test_random_settings();
        logic [31:0]       phase;
        logic [31:0]       junk;
        logic [AXIS_W-1:0] axis_code;
        for (int s = 0; s < 12; s++) begin
            case (s)
                0:       phase = 32'h7FFF_FFFF;
                1:       phase = 32'h8000_0000;
                2:       phase = 32'h0000_0000;
                3:       phase = 32'h0000_0001;
                4:       phase = 32'hFFFF_FFFF;
                5:       phase = $urandom_range(0, 4095);
                default: phase = $urandom;
            endcase
            case (s % 4)
                0:       axis_code = AXIS_Z;
                1:       axis_code = AXIS_X;
                2:       axis_code = AXIS_Y;
                default: axis_code = AXIS_NONE;
            endcase
            junk = $urandom_range(0, 1) ? $urandom : 32'd0;
            program_regs(phase, {junk[31:AXIS_W], axis_code}, s[0]);
            stream_random(62, s != 3);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_each_axis();
        test_angle_wrap();
        test_random_settings();
        wait_idle();

        $display("Sent %0d spins under %0d register settings, checked %0d rotations",
                 spins_sent, settings_used, rotations_seen);
        $display("Covered all axis codes, saturation, angle wrap and random stalls");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/spr_pkg.sv
rtl/spin_precession_rotate.sv
verif/tb_spin_precession_rotate.sv
